// ===== hdl/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // fixed field widths
  localparam int CELL_IDX_W = 11;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;

  // control codes
  localparam logic [CHAR_W-1:0] CR_CODE = 8'h0D;
  localparam logic [CHAR_W-1:0] LF_CODE = 8'h0A;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // attribute after reset
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0A;

  // input word
  typedef struct packed {
    logic                  op;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [CELL_IDX_W-1:0] cursor_pos;
    logic [CHAR_W-1:0]     read_char;
    logic [ATTR_W-1:0]     read_attr;
    logic                  scrolled;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/tccw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console: screen store of character/attribute cells with a cursor.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result shows on
// out_word for exactly one cycle with out_valid, and the receiver cannot stall
// it. A put without scroll returns its result the next cycle, and a new word
// may be started in that same cycle. A read passes the registered RAM read and
// the ST_READ_WAIT state before its result is registered. A put that runs past
// the last cell scrolls: the single RAM port pair moves one cell a cycle (copy
// of all but one row, fill of the bottom row, then ST_FINISH drains the write
// stage). After reset a clearing pass writes every cell to zero with busy high;
// attribute writes on cfg_ are taken at any time.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tccw_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output tccw_pkg::out_word_t   out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0] cfg_data
);

  import tccw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int SW         = AW + 1;
  localparam int COLW       = $clog2(COLUMNS);
  localparam int PW         = (SW > CELL_IDX_W) ? SW : CELL_IDX_W;

  localparam logic [AW-1:0]   LAST_CELL   = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]   BOTTOM_ROW  = AW'(CELL_COUNT - COLUMNS);
  localparam logic [AW-1:0]   LAST_COPY   = AW'(CELL_COUNT - COLUMNS - 1);
  localparam logic [AW-1:0]   COLS_A      = AW'(COLUMNS);
  localparam logic [SW-1:0]   COLS_S      = SW'(COLUMNS);
  localparam logic [SW-1:0]   COUNT_S     = SW'(CELL_COUNT);
  localparam logic [PW-1:0]   COUNT_P     = PW'(CELL_COUNT);
  localparam logic [COLW-1:0] LAST_COL    = COLW'(COLUMNS - 1);

  // state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [COLW-1:0]   col_r, col_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic              oob_r, oob_nxt;
  logic              wstg_vld_r, wstg_vld_nxt;
  logic              wstg_fill_r, wstg_fill_nxt;
  logic [AW-1:0]     wstg_addr_r, wstg_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // ram ports
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  // datapath helpers
  logic              accept;
  logic              put_wr;
  logic              is_cr;
  logic              is_lf;
  logic [SW-1:0]     cur_base;
  logic [SW-1:0]     cur_new;
  logic [COLW-1:0]   col_new;
  logic [PW-1:0]     idx_w;
  logic              idx_ok;
  logic [PW-1:0]     new_pos_w;
  logic [PW-1:0]     cur_pos_w;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // cursor arithmetic for a put
  assign is_cr    = (in_word.char_code == CR_CODE);
  assign is_lf    = (in_word.char_code == LF_CODE);
  assign cur_base = {1'b0, cursor_r};

  always_comb begin
    priority if (is_cr) begin
      cur_new = cur_base - SW'(col_r);
      col_new = '0;
    end else if (is_lf) begin
      cur_new = cur_base + COLS_S - SW'(col_r);
      col_new = '0;
    end else begin
      cur_new = cur_base + SW'(1);
      col_new = (col_r == LAST_COL) ? '0 : col_r + COLW'(1);
    end
  end

  // read index range check and position formatting
  assign idx_w     = PW'(in_word.cell_index);
  assign idx_ok    = (idx_w < COUNT_P);
  assign new_pos_w = PW'(cur_new);
  assign cur_pos_w = PW'(cursor_r);

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      wstg_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      wstg_vld_r  <= wstg_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    oob_r       <= oob_nxt;
    wstg_fill_r <= wstg_fill_nxt;
    wstg_addr_r <= wstg_addr_nxt;
    out_word_r  <= out_word_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    oob_nxt       = oob_r;
    wstg_vld_nxt  = 1'b0;
    wstg_fill_nxt = 1'b0;
    wstg_addr_nxt = ptr_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = ptr_r + COLS_A;
    put_wr        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (in_word.op == OP_READ) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_w[AW-1:0];
            oob_nxt     = !idx_ok;
            state_nxt   = ST_READ_WAIT;
          end else begin
            put_wr = !is_cr && !is_lf;
            if (cur_new >= COUNT_S) begin
              // past the last cell: scroll up one row
              cursor_nxt = BOTTOM_ROW;
              col_nxt    = '0;
              ptr_nxt    = '0;
              state_nxt  = ST_SCROLL_COPY;
            end else begin
              cursor_nxt    = cur_new[AW-1:0];
              col_nxt       = col_new;
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{cursor_pos: new_pos_w[CELL_IDX_W-1:0],
                                read_char:  '0,
                                read_attr:  '0,
                                scrolled:   1'b0};
            end
          end
        end
      end

      ST_READ_WAIT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{cursor_pos: cur_pos_w[CELL_IDX_W-1:0],
                          read_char:  oob_r ? '0 : ram_rd_data[CHAR_W-1:0],
                          read_attr:  oob_r ? '0 : ram_rd_data[CELL_W-1:CHAR_W],
                          scrolled:   1'b0};
        state_nxt     = ST_IDLE;
      end

      ST_SCROLL_COPY: begin
        // read one row below, write back through the write stage
        ram_rd_en     = 1'b1;
        ram_rd_addr   = ptr_r + COLS_A;
        wstg_vld_nxt  = 1'b1;
        wstg_addr_nxt = ptr_r;
        ptr_nxt       = ptr_r + AW'(1);
        if (ptr_r == LAST_COPY) begin
          state_nxt = ST_SCROLL_FILL;
        end
      end

      ST_SCROLL_FILL: begin
        // blank the bottom row
        wstg_vld_nxt  = 1'b1;
        wstg_fill_nxt = 1'b1;
        wstg_addr_nxt = ptr_r;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{cursor_pos: cur_pos_w[CELL_IDX_W-1:0],
                          read_char:  '0,
                          read_attr:  '0,
                          scrolled:   1'b1};
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // write port select
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cursor_r;
    ram_wr_data = {attr_r, in_word.char_code};
    priority if (wstg_vld_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wstg_addr_r;
      ram_wr_data = wstg_fill_r ? {attr_r, {CHAR_W{1'b0}}} : ram_rd_data;
    end else if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = ptr_r;
      ram_wr_data = '0;
    end else if (put_wr) begin
      ram_wr_en = 1'b1;
    end
  end

  // screen store
  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
